// ===== rtl/core/htbd_pkg.sv =====
// ----------------------------------------------------------------------------
// htbd_pkg: shared types and constants of the Huffman tree bit decoder
// Item formats, node layout, mode and status codes, controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package htbd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int SYMBOL_COUNT = 256;
  localparam int NODE_AW      = $clog2(NODE_COUNT);
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);
  localparam int CFG_AW       = 1;
  localparam int CFG_DW       = 9;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_BIT  = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_TREE   = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  localparam logic [CFG_AW-1:0] REG_TREE_PRESENT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_ROOT_NODE    = 1'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  node_index;
    logic        node_is_leaf;
    logic [7:0]  node_symbol;
    logic [8:0]  left_child;
    logic [8:0]  right_child;
    logic        code_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       leaf;
    logic [7:0] sym;
    logic [8:0] left;
    logic [8:0] right;
  } node_t;

  // node memory read address source
  typedef enum logic [1:0] {
    RD_ROOT,     // configured root
    RD_CUR,      // child of the cached current node, bit from the input
    RD_RDATA     // child of the node just read, latched bit
  } rd_sel_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_SYMBOL,
    EMIT_NO_TREE,
    EMIT_TRUNC
  } emit_t;

  typedef struct packed {
    logic    capture;   // latch the code bit of an accepted item
    logic    load;      // write the node table
    logic    rd_en;
    rd_sel_t rd_sel;
    emit_t   emit;
    logic    advance;   // walk steps to the node just read
    logic    go_root;
  } dp_cmd_t;

  typedef struct packed {
    logic tree_present;
    logic walk_active;
    logic rd_leaf;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/huffman_tree_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder: bit-serial Huffman tree-walk decoder
// Walks a software-loaded node table one code bit per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are transferred when start is high and busy is low. A load
//   item writes one node in its accept cycle; mode 3 and an end item at the
//   root do nothing. Each result (symbol, status) is shown for one cycle with
//   done high, the cycle after the item finishes; the receiver cannot stall.
//   Steps per item:
//     load, end, bit with no tree: handled in the accept cycle, result (if any) in the cycle after.
//     bit mid-code: one read of the child from the node memory (the current
//       node is kept in a register).
//     bit at the root: root read, then child read; no child read when the
//       root is a leaf.
//   The node memory has a single port with registered read data.
//   Registers (cfg_we, cfg_addr, cfg_wdata) are written at once and must be
//   changed by the user only while the block is idle; the block does not
//   enforce this. Synchronous reset clears the walk, the registers and the
//   result strobe; node table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_bit_decoder (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire htbd_pkg::in_item_t                    in_item,
  output logic                                       done,
  output htbd_pkg::out_item_t                        result,
  input  wire logic                                  cfg_we,
  input  wire logic [htbd_pkg::CFG_AW-1:0]           cfg_addr,
  input  wire logic [htbd_pkg::CFG_DW-1:0]           cfg_wdata
);

  htbd_pkg::dp_cmd_t    cmd;
  htbd_pkg::dp_status_t status;
  logic                 accept;

  assign accept = start && !busy;

  htbd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (in_item.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  htbd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .result    (result)
  );

  // only a code bit starts a walk
  a_busy_from_bit: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && in_item.mode == htbd_pkg::MODE_BIT))
    else $error("walk started by an item that is not a code bit");

  // error results carry no symbol
  a_err_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != htbd_pkg::ST_OK |-> result.symbol == '0)
    else $error("error result with nonzero symbol");

  // a result follows an accept or a busy cycle
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept) || $past(busy))
    else $error("result without an item in progress");

  // node table is never written while a walk reads it
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("node write during a walk");

endmodule

`default_nettype wire

// ===== rtl/core/htbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htbd_ctrl: decoder controller
// Sequences node memory reads for each code bit and picks the result to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [1:0]           mode,
  input  wire htbd_pkg::dp_status_t status,
  output htbd_pkg::dp_cmd_t         cmd,
  output logic                      busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROOT,
    S_CHILD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_sel  = htbd_pkg::RD_ROOT;
    cmd.emit    = htbd_pkg::EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          case (mode)
            htbd_pkg::MODE_LOAD: begin
              cmd.load = 1'b1;
            end
            htbd_pkg::MODE_BIT: begin
              if (!status.tree_present) begin
                cmd.emit    = htbd_pkg::EMIT_NO_TREE;
                cmd.go_root = 1'b1;
              end else if (status.walk_active) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = htbd_pkg::RD_CUR;
                state_next = S_CHILD;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = htbd_pkg::RD_ROOT;
                state_next = S_ROOT;
              end
            end
            htbd_pkg::MODE_END: begin
              if (status.walk_active) begin
                cmd.emit    = htbd_pkg::EMIT_TRUNC;
                cmd.go_root = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROOT: begin
        // single-symbol tree: the root leaf answers every bit
        if (status.rd_leaf) begin
          cmd.emit   = htbd_pkg::EMIT_SYMBOL;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = htbd_pkg::RD_RDATA;
          state_next = S_CHILD;
        end
      end
      S_CHILD: begin
        if (status.rd_leaf) begin
          cmd.emit    = htbd_pkg::EMIT_SYMBOL;
          cmd.go_root = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/htbd_datapath.sv =====
// ----------------------------------------------------------------------------
// htbd_datapath: node table, walk state, configuration and result registers
// Node memory has one port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [htbd_pkg::CFG_AW-1:0]           cfg_addr,
  input  wire logic [htbd_pkg::CFG_DW-1:0]           cfg_wdata,
  input  wire htbd_pkg::in_item_t                    in_item,
  input  wire htbd_pkg::dp_cmd_t                     cmd,
  output htbd_pkg::dp_status_t                       status,
  output logic                                       done,
  output htbd_pkg::out_item_t                        result
);

  htbd_pkg::node_t mem [htbd_pkg::NODE_COUNT];

  htbd_pkg::node_t                 rd_data;
  htbd_pkg::node_t                 cur_node;   // copy of the node at walk_position
  htbd_pkg::node_t                 wr_node;
  logic [htbd_pkg::NODE_AW-1:0]    rd_addr;
  logic [htbd_pkg::NODE_AW-1:0]    next_idx;
  logic [htbd_pkg::NODE_AW-1:0]    walk_position;
  logic                            walk_active;
  logic                            tree_present;
  logic [htbd_pkg::NODE_AW-1:0]    root_node;
  logic                            bit_q;

  assign wr_node.leaf  = in_item.node_is_leaf;
  assign wr_node.sym   = in_item.node_symbol;
  assign wr_node.left  = in_item.left_child;
  assign wr_node.right = in_item.right_child;

  always_comb begin
    case (cmd.rd_sel)
      htbd_pkg::RD_ROOT:  rd_addr = root_node;
      htbd_pkg::RD_CUR:   rd_addr = in_item.code_bit ? cur_node.right : cur_node.left;
      htbd_pkg::RD_RDATA: rd_addr = bit_q ? rd_data.right : rd_data.left;
      default:            rd_addr = root_node;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_item.node_index] <= wr_node;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bit_q <= in_item.code_bit;
    end
    if (cmd.rd_en) begin
      next_idx <= rd_addr;
    end
    if (cmd.advance) begin
      cur_node <= rd_data;
    end else if (cmd.load && walk_active && in_item.node_index == walk_position) begin
      cur_node <= wr_node;
    end
    case (cmd.emit)
      htbd_pkg::EMIT_SYMBOL: begin
        result.symbol <= rd_data.sym;
        result.status <= htbd_pkg::ST_OK;
      end
      htbd_pkg::EMIT_NO_TREE: begin
        result.symbol <= '0;
        result.status <= htbd_pkg::ST_NO_TREE;
      end
      htbd_pkg::EMIT_TRUNC: begin
        result.symbol <= '0;
        result.status <= htbd_pkg::ST_TRUNCATED;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active   <= 1'b0;
      walk_position <= '0;
      tree_present  <= 1'b0;
      root_node     <= '0;
      done          <= 1'b0;
    end else begin
      done <= (cmd.emit != htbd_pkg::EMIT_NONE);
      if (cmd.go_root) begin
        walk_active   <= 1'b0;
        walk_position <= '0;
      end else if (cmd.advance) begin
        walk_active   <= 1'b1;
        walk_position <= next_idx;
      end
      if (cfg_we) begin
        case (cfg_addr)
          htbd_pkg::REG_TREE_PRESENT: tree_present <= cfg_wdata[0];
          htbd_pkg::REG_ROOT_NODE:    root_node    <= cfg_wdata[htbd_pkg::NODE_AW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign status.tree_present = tree_present;
  assign status.walk_active  = walk_active;
  assign status.rd_leaf      = rd_data.leaf;

endmodule

`default_nettype wire
